// File: rtl/frame_receiver_sum_checksum_defines.svh
// Assertion macros for the frame receiver with additive checksum.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef FRAME_RECEIVER_SUM_CHECKSUM_DEFINES_SVH
`define FRAME_RECEIVER_SUM_CHECKSUM_DEFINES_SVH

`ifndef SYNTHESIS
`define FRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/frs_pkg.sv
// Shared types and constants for the frame receiver with additive checksum.
// No dependencies; imported by every module of the block.
package frs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned HCNT_W  = 2;

    typedef enum logic
    {
        OP_ARM  = 1'b0,
        OP_BYTE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0]
    {
        K_ARMED   = 3'd0,
        K_REFUSED = 3'd1,
        K_HEADER  = 3'd2,
        K_PAYLOAD = 3'd3,
        K_GOOD    = 3'd4,
        K_BAD     = 3'd5,
        K_IGNORED = 3'd6
    } kind_t;

    localparam logic [HCNT_W-1:0] HC_ID     = 2'd0;
    localparam logic [HCNT_W-1:0] HC_LEN_HI = 2'd1;
    localparam logic [HCNT_W-1:0] HC_LEN_LO = 2'd2;

    typedef struct packed
    {
        op_t               opcode;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed
    {
        kind_t             result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_index;
        logic [BYTE_W-1:0] frame_id;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
    } result_t;

endpackage

// File: rtl/frs_in_stage.sv
// Input register of the frame receiver: captures one item per cycle while in_ready is high.
// Depends on frs_pkg.
module frs_in_stage
    import frs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              advance,
    output logic              item_valid,
    output item_t             item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.opcode  <= op_t'(opcode);
            item_reg.rx_byte <= rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/frs_core.sv
// Deframer state and per-item step: header capture, payload sum, checksum compare.
// Depends on frs_pkg and frame_receiver_sum_checksum_defines.svh.
`include "frame_receiver_sum_checksum_defines.svh"

module frs_core
    import frs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_data,
    input  logic        step,
    input  item_t       item,
    output result_t     res
);

    logic              enable_reg;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [HCNT_W-1:0] hcount_reg;
    logic [HCNT_W-1:0] hcount_next;
    logic [BYTE_W-1:0] id_reg;
    logic [BYTE_W-1:0] id_next;
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic [LEN_W-1:0]  position_reg;
    logic [LEN_W-1:0]  position_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [LEN_W-1:0]  position_inc;
    logic [LEN_W-1:0]  length_full;
    logic              arm_ok;

    assign arm_ok       = enable_reg && (phase_reg == PH_IDLE);
    assign position_inc = position_reg + LEN_W'(1);
    assign length_full  = {length_reg[LEN_W-1:BYTE_W], item.rx_byte};

    always_comb
    begin
        phase_next    = phase_reg;
        hcount_next   = hcount_reg;
        id_next       = id_reg;
        length_next   = length_reg;
        position_next = position_reg;
        sum_next      = sum_reg;
        if (item.opcode == OP_ARM)
        begin
            if (arm_ok)
            begin
                phase_next    = PH_HEADER;
                hcount_next   = HC_ID;
                id_next       = '0;
                length_next   = '0;
                position_next = '0;
                sum_next      = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    priority if (hcount_reg == HC_ID)
                    begin
                        id_next     = item.rx_byte;
                        hcount_next = HC_LEN_HI;
                    end
                    else if (hcount_reg == HC_LEN_HI)
                    begin
                        length_next = {item.rx_byte, {BYTE_W{1'b0}}};
                        hcount_next = HC_LEN_LO;
                    end
                    else
                    begin
                        length_next = length_full;
                        hcount_next = HC_ID;
                        phase_next  = (length_full == '0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_next      = sum_reg + item.rx_byte;
                    position_next = position_inc;
                    if (position_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_IDLE;
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res               = '0;
        res.result_kind   = K_IGNORED;
        res.frame_id      = id_next;
        res.frame_length  = length_next;
        res.computed_sum  = sum_next;
        if (item.opcode == OP_ARM)
        begin
            res.result_kind = arm_ok ? K_ARMED : K_REFUSED;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    res.result_kind = K_HEADER;
                end
                PH_PAYLOAD:
                begin
                    res.result_kind   = K_PAYLOAD;
                    res.payload_byte  = item.rx_byte;
                    res.payload_index = position_reg;
                end
                PH_CHECK:
                begin
                    res.result_kind  = (item.rx_byte == sum_reg) ? K_GOOD : K_BAD;
                    res.received_sum = item.rx_byte;
                end
                PH_IDLE:
                begin
                    res.result_kind = K_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            phase_reg    <= PH_IDLE;
            hcount_reg   <= HC_ID;
            id_reg       <= '0;
            length_reg   <= '0;
            position_reg <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                enable_reg <= cfg_data;
            end
            if (step)
            begin
                phase_reg    <= phase_next;
                hcount_reg   <= hcount_next;
                id_reg       <= id_next;
                length_reg   <= length_next;
                position_reg <= position_next;
                sum_reg      <= sum_next;
            end
        end
    end

    `FRS_ASSERT(a_payload_end, clk, rst_n, (step && item.opcode == OP_BYTE && phase_reg == PH_PAYLOAD && position_inc >= length_reg) |=> (phase_reg == PH_CHECK), "payload end did not move to checksum")
    `FRS_ASSERT(a_payload_bound, clk, rst_n, (phase_reg == PH_PAYLOAD) |-> (position_reg < length_reg), "payload position past frame length")
    `FRS_ASSERT(a_hold_sum, clk, rst_n, !step |=> $stable(sum_reg) && $stable(position_reg), "state moved without an item")
    `FRS_ASSERT_ALWAYS(a_idle_header, clk, (phase_reg == PH_IDLE) |-> (hcount_reg == HC_ID), "header count left open in idle")

endmodule

// File: rtl/frs_out_stage.sv
// Result register of the frame receiver: holds one result until taken.
// Depends on frs_pkg.
module frs_out_stage
    import frs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  result_t           res,
    output logic              advance,
    output logic              step,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] result_kind,
    output logic [BYTE_W-1:0] payload_byte,
    output logic [LEN_W-1:0]  payload_index,
    output logic [BYTE_W-1:0] frame_id,
    output logic [LEN_W-1:0]  frame_length,
    output logic [BYTE_W-1:0] computed_sum,
    output logic [BYTE_W-1:0] received_sum
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign advance    = !valid_reg || out_ready;
    assign step       = item_valid && advance;
    assign valid_next = advance ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign result_kind   = res_reg.result_kind;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_index = res_reg.payload_index;
    assign frame_id      = res_reg.frame_id;
    assign frame_length  = res_reg.frame_length;
    assign computed_sum  = res_reg.computed_sum;
    assign received_sum  = res_reg.received_sum;

endmodule

// File: rtl/frame_receiver_sum_checksum.sv
// Frame receiver with additive checksum: ID byte, 16-bit length, payload, sum byte.
// Input items (opcode, rx_byte) enter on in_valid/in_ready; opcode 0 arms the
// receiver, opcode 1 delivers one received byte. Each item yields exactly one
// result on out_valid/out_ready: armed, refused, header, payload (with index),
// frame good, checksum bad, or ignored, plus the captured ID, length and sum.
// The enable register is written on cfg_valid/cfg_ready (cfg_ready is always
// high) and gates arming only; a frame in progress runs to its end.
// An accepted item passes the input register and the combinational state update
// logic; the result register loads its result when that register may advance.
// Throughput: one item per cycle while out_ready is high.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready then drops until out_ready returns.
// Reset clears the enable, returns the receiver to idle, clears the captured
// fields and empties both registers. Depends on frs_pkg and the submodules.
module frame_receiver_sum_checksum
    import frs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] result_kind,
    output logic [BYTE_W-1:0] payload_byte,
    output logic [LEN_W-1:0]  payload_index,
    output logic [BYTE_W-1:0] frame_id,
    output logic [LEN_W-1:0]  frame_length,
    output logic [BYTE_W-1:0] computed_sum,
    output logic [BYTE_W-1:0] received_sum
);

    logic    advance;
    logic    step;
    logic    item_valid;
    item_t   item;
    result_t res;

    assign cfg_ready = 1'b1;

    frs_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    frs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item),
        .res       (res)
    );

    frs_out_stage u_out_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .res           (res),
        .advance       (advance),
        .step          (step),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_id      (frame_id),
        .frame_length  (frame_length),
        .computed_sum  (computed_sum),
        .received_sum  (received_sum)
    );

endmodule

// File: tb/tb_frame_receiver_sum_checksum.sv
// Self-checking testbench for frame_receiver_sum_checksum: directed table, then random frames.
// Takes each result from the table or its own deframer model; depends on frs_pkg and the RTL.
`timescale 1ns / 100ps

module tb_frame_receiver_sum_checksum;
    import frs_pkg::*;

    typedef enum logic
    {
        ACT_ITEM = 1'b0,
        ACT_CFG  = 1'b1
    } act_t;

    typedef struct packed
    {
        act_t              act;
        op_t               op;
        logic [BYTE_W-1:0] data;
        bit                typed;
        kind_t             kind;
        logic [BYTE_W-1:0] id;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] rsum;
    } row_t;

    localparam row_t DIRECTED [0:26] = '{
        '{ACT_ITEM, OP_ARM,  8'h00, 1'b1, K_REFUSED, 8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'hFF, 1'b1, K_IGNORED, 8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_CFG,  OP_ARM,  8'h01, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_ARM,  8'h00, 1'b1, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_ARM,  8'hFF, 1'b1, K_REFUSED, 8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'hA5, 1'b1, K_HEADER,  8'hA5, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h00, 1'b1, K_HEADER,  8'hA5, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h03, 1'b1, K_HEADER,  8'hA5, 16'h0003, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'hFF, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h80, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_CFG,  OP_ARM,  8'h00, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h01, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h80, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_ARM,  8'h55, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h7E, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_CFG,  OP_ARM,  8'h01, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_ARM,  8'h00, 1'b1, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h00, 1'b1, K_HEADER,  8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h00, 1'b1, K_HEADER,  8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h00, 1'b1, K_HEADER,  8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h00, 1'b1, K_GOOD,    8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_ARM,  8'h00, 1'b1, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h5A, 1'b1, K_HEADER,  8'h5A, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h00, 1'b1, K_HEADER,  8'h5A, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h01, 1'b1, K_HEADER,  8'h5A, 16'h0001, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h10, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00},
        '{ACT_ITEM, OP_BYTE, 8'h11, 1'b0, K_ARMED,   8'h00, 16'h0000, 8'h00, 8'h00}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_data = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              opcode = 1'b0;
    logic [BYTE_W-1:0] rx_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_index;
    logic [BYTE_W-1:0] frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] computed_sum;
    logic [BYTE_W-1:0] received_sum;

    frame_receiver_sum_checksum dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_id      (frame_id),
        .frame_length  (frame_length),
        .computed_sum  (computed_sum),
        .received_sum  (received_sum)
    );

    // deframer state as the block should hold it
    bit                rx_enable = 1'b0;
    phase_t            rx_phase = PH_IDLE;
    logic [HCNT_W-1:0] hdr_count = HC_ID;
    logic [BYTE_W-1:0] cap_id = '0;
    logic [LEN_W-1:0]  cap_len = '0;
    logic [LEN_W-1:0]  byte_pos = '0;
    logic [BYTE_W-1:0] run_sum = '0;

    result_t frame_events_q[$];
    int      mismatches = 0;
    int      items_sent = 0;
    bit      idle_on = 1'b1;
    bit      hold_req = 1'b0;
    bit      hold_done = 1'b0;

    always #2 clk = ~clk;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic result_t deframe_step(op_t op, logic [BYTE_W-1:0] b);
        result_t r;
        r = '0;
        r.result_kind = K_IGNORED;
        if (op == OP_ARM)
        begin
            if (rx_enable && rx_phase == PH_IDLE)
            begin
                rx_phase = PH_HEADER;
                hdr_count = HC_ID;
                cap_id = '0;
                cap_len = '0;
                byte_pos = '0;
                run_sum = '0;
                r.result_kind = K_ARMED;
            end
            else
            begin
                r.result_kind = K_REFUSED;
            end
        end
        else
        begin
            case (rx_phase)
                PH_HEADER:
                begin
                    r.result_kind = K_HEADER;
                    if (hdr_count == HC_ID)
                    begin
                        cap_id = b;
                        hdr_count = HC_LEN_HI;
                    end
                    else if (hdr_count == HC_LEN_HI)
                    begin
                        cap_len = {b, 8'h00};
                        hdr_count = HC_LEN_LO;
                    end
                    else
                    begin
                        cap_len = {cap_len[15:8], b};
                        hdr_count = HC_ID;
                        rx_phase = (cap_len == '0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    r.result_kind = K_PAYLOAD;
                    r.payload_byte = b;
                    r.payload_index = byte_pos;
                    run_sum = run_sum + b;
                    byte_pos = byte_pos + 16'd1;
                    if (byte_pos >= cap_len)
                        rx_phase = PH_CHECK;
                end
                PH_CHECK:
                begin
                    r.received_sum = b;
                    r.result_kind = (b == run_sum) ? K_GOOD : K_BAD;
                    rx_phase = PH_IDLE;
                end
                default:
                    r.result_kind = K_IGNORED;
            endcase
        end
        r.frame_id = cap_id;
        r.frame_length = cap_len;
        r.computed_sum = run_sum;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // hold valid and payload until accepted; valid stays high unless an idle gap precedes the next item
    task automatic send_item(op_t op, logic [BYTE_W-1:0] b, bit typed, result_t typed_exp);
        int      gap;
        result_t predicted;
        gap = 0;
        if (idle_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        predicted = deframe_step(op, b);
        frame_events_q.push_back(typed ? typed_exp : predicted);
        items_sent++;
        if (items_sent == 400)
            hold_req = 1'b1;
        if (items_sent >= 1350)
            idle_on = 1'b0;
    endtask

    // drain the block before touching the enable
    task automatic write_enable(bit v);
        in_valid <= 1'b0;
        while (frame_events_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rx_enable = v;
    endtask

    task automatic send_frame();
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                stop;
        int                sel;
        sum = '0;
        if ($urandom_range(0, 9) == 0)
            write_enable($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        sel = $urandom_range(0, 99);
        if (sel < 85)
            len = LEN_W'($urandom_range(0, 12));
        else if (sel < 97)
            len = LEN_W'($urandom_range(13, 80));
        else
            len = LEN_W'($urandom_range(256, 300));
        stop = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len + 3) : len + 4;
        send_item(OP_ARM, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        for (int k = 0; k < stop; k++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_item(OP_ARM, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            if (k == 0)
                b = BYTE_W'($urandom_range(0, 255));
            else if (k == 1)
                b = len[15:8];
            else if (k == 2)
                b = len[7:0];
            else if (k < len + 3)
            begin
                b = BYTE_W'($urandom_range(0, 255));
                sum = sum + b;
            end
            else
                b = ($urandom_range(0, 9) < 7) ? sum : BYTE_W'($urandom_range(0, 255));
            send_item(OP_BYTE, b, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        row_t    row;
        result_t typed_exp;
        do @(posedge clk); while (!rst_n);
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            if (row.act == ACT_CFG)
            begin
                write_enable(row.data[0]);
            end
            else
            begin
                typed_exp = '0;
                typed_exp.result_kind = row.kind;
                typed_exp.frame_id = row.id;
                typed_exp.frame_length = row.len;
                typed_exp.computed_sum = row.sum;
                typed_exp.received_sum = row.rsum;
                send_item(row.op, row.data, row.typed, typed_exp);
            end
        end
        while (items_sent < 1550)
            send_frame();
        in_valid <= 1'b0;
        while (frame_events_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : receiver
        int n;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                n = 0;
                while (n < 300)
                begin
                    @(posedge clk);
                    n++;
                end
                hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_events_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual kind %0d",
                         $time, result_kind);
                mismatches++;
            end
            else
            begin
                want = frame_events_q.pop_front();
                check_field("result_kind", 16'(want.result_kind), 16'(result_kind));
                check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
                check_field("payload_index", want.payload_index, payload_index);
                check_field("frame_id", 16'(want.frame_id), 16'(frame_id));
                check_field("frame_length", want.frame_length, frame_length);
                check_field("computed_sum", 16'(want.computed_sum), 16'(computed_sum));
                check_field("received_sum", 16'(want.received_sum), 16'(received_sum));
            end
        end
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/frs_pkg.sv
rtl/frs_in_stage.sv
rtl/frs_core.sv
rtl/frs_out_stage.sv
rtl/frame_receiver_sum_checksum.sv
tb/tb_frame_receiver_sum_checksum.sv
